### hdl/assert_macros.svh
// Assertion helpers for the checks in the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The expression must hold in every cycle out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

### hdl/anh_pkg.sv
`timescale 1ns / 1ps

package anh_pkg;

    localparam int CHANNELS        = 8;
    localparam int CH_W            = 3;
    localparam int CH_IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_W        = 16;
    localparam int PCT_W           = 7;
    localparam int MUL_W           = 2 * SAMPLE_W;
    localparam int PROD_W          = SAMPLE_W + PCT_W;
    localparam int DIV_STEPS       = SAMPLE_W;
    localparam int CNT_W           = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_W-1:0] RANGE_MAX_START = 16'd0;
    localparam logic [SAMPLE_W-1:0] RANGE_MIN_START = 16'd65535;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST  = 16'd1000;
    localparam logic [PCT_W-1:0]    UPPER_PCT_RST   = 7'd20;
    localparam logic [PCT_W-1:0]    LOWER_PCT_RST   = 7'd20;
    localparam logic [PCT_W-1:0]    PCT_FULL        = 7'd100;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = SAMPLE_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_PCT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_PCT  = 2'd2;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int TUSER_W     = CH_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_MULT,
        ST_DIV,
        ST_THRESH,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic range_upd;
        logic mult_load;
        logic div_step;
        logic thresh;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;

    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] p);
        return (p > PCT_FULL) ? PCT_FULL : p;
    endfunction

endpackage

### hdl/autorange_normalise_hysteresis.sv
// A request is taken only in idle, then passes the range, multiply, divide, threshold
// and decide states, with a 16-step radix-2 divider; decide stalls on a full output.
// The next request is taken while a finished result still waits in the output register.
// Reset is synchronous and active low; it restores the configuration registers to their
// defaults, the tracked ranges to their start values and every flag to black at once.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module autorange_normalise_hysteresis import anh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: raw_sample[15:0].
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: channel[2:0].
    input  logic [TUSER_W-1:0]     s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: normalised[15:0], is_white[16], zero fill[23:17].
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: out_channel[2:0].
    output logic [TUSER_W-1:0]     m_axis_tuser
);

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [CH_W-1:0]     w_out_channel;
    logic [SAMPLE_W-1:0] w_normalised;
    logic                w_is_white;

    anh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    anh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_channel     (s_axis_tuser),
        .i_raw_sample  (s_axis_tdata[SAMPLE_W-1:0]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_channel (w_out_channel),
        .o_normalised  (w_normalised),
        .o_is_white    (w_is_white)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - SAMPLE_W - 1)'(0), w_is_white, w_normalised};
    assign m_axis_tuser = w_out_channel;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_SAME(a_valid_from_load, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_cmd.result_load))
    `ASSERT_ALWAYS(a_one_step, i_clk, i_rst_n, $onehot0({w_cmd.range_upd, w_cmd.mult_load, w_cmd.div_step, w_cmd.thresh, w_cmd.result_load}))

endmodule

### hdl/anh_ctrl.sv
`timescale 1ns / 1ps

module anh_ctrl import anh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RANGE;
                end
            end
            ST_RANGE:  n_state = ST_MULT;
            ST_MULT:   n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_THRESH;
                end
            end
            ST_THRESH: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_RANGE:  o_cmd.range_upd = 1'b1;
            ST_MULT:   o_cmd.mult_load = 1'b1;
            ST_DIV:    o_cmd.div_step  = 1'b1;
            ST_THRESH: o_cmd.thresh    = 1'b1;
            ST_DECIDE: o_cmd.result_load = w_slot_free;
            default:   o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.result_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hdl/anh_dp.sv
`timescale 1ns / 1ps

module anh_dp import anh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [CH_W-1:0]       o_out_channel,
    output logic [SAMPLE_W-1:0]   o_normalised,
    output logic                  o_is_white
);

    logic [SAMPLE_W-1:0] r_full_scale;
    logic [PCT_W-1:0]    r_upper_pct;
    logic [PCT_W-1:0]    r_lower_pct;

    logic [SAMPLE_W-1:0] r_range_high [CHANNELS];
    logic [SAMPLE_W-1:0] r_range_low  [CHANNELS];
    logic [CHANNELS-1:0] r_white;

    logic [CH_W-1:0]     r_ch;
    logic [SAMPLE_W-1:0] r_raw;
    logic [SAMPLE_W-1:0] r_num;
    logic [SAMPLE_W-1:0] r_den;
    logic                r_flat;
    logic [SAMPLE_W:0]   r_rem;
    logic [SAMPLE_W-1:0] r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_norm;
    logic [PROD_W-1:0]   r_lhs;
    logic [PROD_W-1:0]   r_up_rhs;
    logic [PROD_W-1:0]   r_dn_rhs;
    logic [CH_W-1:0]     r_out_ch;
    logic [SAMPLE_W-1:0] r_out_norm;
    logic                r_out_white;

    logic [CH_IDX_W-1:0] w_idx;
    logic                w_in_range;
    logic [SAMPLE_W-1:0] w_hi_cur;
    logic [SAMPLE_W-1:0] w_lo_cur;
    logic [SAMPLE_W-1:0] w_hi_new;
    logic [SAMPLE_W-1:0] w_lo_new;
    logic [MUL_W-1:0]    w_prod;
    logic [SAMPLE_W:0]   w_rem_sh;
    logic                w_rem_ge;
    logic [SAMPLE_W:0]   w_rem_nx;
    logic [SAMPLE_W-1:0] w_norm;
    logic [PCT_W-1:0]    w_up;
    logic [PCT_W-1:0]    w_dn;
    logic                w_white;

    assign w_idx      = r_ch[CH_IDX_W-1:0];
    assign w_in_range = (32'(r_ch) < CHANNELS);
    assign w_hi_cur   = r_range_high[w_idx];
    assign w_lo_cur   = r_range_low[w_idx];
    assign w_hi_new   = (r_raw >= w_hi_cur) ? r_raw : w_hi_cur;
    assign w_lo_new   = (r_raw <= w_lo_cur) ? r_raw : w_lo_cur;

    assign w_prod     = MUL_W'(r_num) * MUL_W'(r_full_scale);

    assign w_rem_sh   = {r_rem[SAMPLE_W-1:0], r_quo[SAMPLE_W-1]};
    assign w_rem_ge   = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx   = w_rem_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;

    assign w_norm     = (r_flat || !w_in_range) ? '0 : r_quo;
    assign w_up       = sat_pct(r_upper_pct);
    assign w_dn       = sat_pct(r_lower_pct);

    always_comb begin
        if (!w_in_range) begin
            w_white = 1'b0;
        end else if (r_lhs >= r_up_rhs) begin
            w_white = 1'b1;
        end else if (r_lhs <= r_dn_rhs) begin
            w_white = 1'b0;
        end else begin
            w_white = r_white[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FULL_SCALE_RST;
            r_upper_pct  <= UPPER_PCT_RST;
            r_lower_pct  <= LOWER_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FULL_SCALE: r_full_scale <= i_cfg_wdata;
                CFG_UPPER_PCT:  r_upper_pct  <= i_cfg_wdata[PCT_W-1:0];
                CFG_LOWER_PCT:  r_lower_pct  <= i_cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_range_high[i] <= RANGE_MAX_START;
                r_range_low[i]  <= RANGE_MIN_START;
            end
            r_white <= '0;
        end else begin
            if (i_cmd.range_upd && w_in_range) begin
                r_range_high[w_idx] <= w_hi_new;
                r_range_low[w_idx]  <= w_lo_new;
            end
            if (i_cmd.result_load && w_in_range) begin
                r_white[w_idx] <= w_white;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mult_load) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch  <= i_channel;
            r_raw <= i_raw_sample;
        end
        if (i_cmd.range_upd) begin
            r_num  <= r_raw - w_lo_new;
            r_den  <= w_hi_new - w_lo_new;
            r_flat <= (w_hi_new == w_lo_new);
        end
        if (i_cmd.mult_load) begin
            r_rem <= {1'b0, w_prod[MUL_W-1:SAMPLE_W]};
            r_quo <= w_prod[SAMPLE_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_nx;
            r_quo <= {r_quo[SAMPLE_W-2:0], w_rem_ge};
        end
        if (i_cmd.thresh) begin
            r_norm   <= w_norm;
            r_lhs    <= PROD_W'(w_norm) * PROD_W'(PCT_FULL);
            r_up_rhs <= PROD_W'(r_full_scale) * PROD_W'(PCT_FULL - w_up);
            r_dn_rhs <= PROD_W'(r_full_scale) * PROD_W'(w_dn);
        end
        if (i_cmd.result_load) begin
            r_out_ch    <= r_ch;
            r_out_norm  <= r_norm;
            r_out_white <= w_white;
        end
    end

    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_out_channel  = r_out_ch;
    assign o_normalised   = r_out_norm;
    assign o_is_white     = r_out_white;

endmodule

### sim/tb_autorange_normalise_hysteresis.sv
`timescale 1ns / 1ps

module tb_autorange_normalise_hysteresis;
    import anh_pkg::*;

    localparam int N_DIRECTED      = 33;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int PRESSURE_PHASE  = 4;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 30;
    localparam int MAX_REPORTS     = 50;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] norm;
        logic                white;
    } t_light_result;

    typedef enum logic {
        STEP_SAMPLE,
        STEP_CONFIG
    } t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        logic [2:0]          sel;
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        logic [SAMPLE_W-1:0] want_norm;
        logic                want_white;
    } t_directed_step;

    localparam t_directed_step DIRECTED [N_DIRECTED] = '{
        '{STEP_SAMPLE, 3'd0, 16'd100,   1'b1, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd0, 16'd0,     1'b1, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd0, 16'd65535, 1'b1, 16'd1000, 1'b1},
        '{STEP_SAMPLE, 3'd0, 16'd40000, 1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd0, 16'd13107, 1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd0, 16'd52428, 1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd1, 16'd65535, 1'b1, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd7, 16'd0,     1'b1, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd7, 16'd65535, 1'b1, 16'd1000, 1'b1},
        '{STEP_CONFIG, 3'(CFG_UPPER_PCT),  16'd100,   1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd7, 16'd0,     1'b1, 16'd0,    1'b1},
        '{STEP_CONFIG, 3'(CFG_UPPER_PCT),  16'd127,   1'b0, 16'd0, 1'b0},
        '{STEP_CONFIG, 3'(CFG_LOWER_PCT),  16'd127,   1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd1, 16'd0,     1'b0, 16'd0,    1'b0},
        '{STEP_CONFIG, 3'(CFG_UPPER_PCT),  16'd0,     1'b0, 16'd0, 1'b0},
        '{STEP_CONFIG, 3'(CFG_LOWER_PCT),  16'd100,   1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd2, 16'd5,     1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd2, 16'd10,    1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd2, 16'd7,     1'b0, 16'd0,    1'b0},
        '{STEP_CONFIG, 3'(CFG_FULL_SCALE), 16'd0,     1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd3, 16'd1,     1'b1, 16'd0,    1'b1},
        '{STEP_SAMPLE, 3'd3, 16'd2,     1'b1, 16'd0,    1'b1},
        '{STEP_CONFIG, 3'(CFG_FULL_SCALE), 16'd65535, 1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd3, 16'd65535, 1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd3, 16'd2,     1'b0, 16'd0,    1'b0},
        '{STEP_CONFIG, 3'(CFG_FULL_SCALE), 16'd1,     1'b0, 16'd0, 1'b0},
        '{STEP_CONFIG, 3'(CFG_LOWER_PCT),  16'd0,     1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd4, 16'd21845, 1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd4, 16'd65535, 1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd4, 16'd0,     1'b0, 16'd0,    1'b0},
        '{STEP_SAMPLE, 3'd4, 16'd43690, 1'b0, 16'd0,    1'b0},
        '{STEP_CONFIG, 3'(CFG_SPARE),      16'hFFFF,  1'b0, 16'd0, 1'b0},
        '{STEP_SAMPLE, 3'd5, 16'd12345, 1'b0, 16'd0,    1'b0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [TUSER_W-1:0]     s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0]     m_axis_tuser;

    logic [SAMPLE_W-1:0] track_max [CHANNELS];
    logic [SAMPLE_W-1:0] track_min [CHANNELS];
    logic                chan_white [CHANNELS];
    logic [SAMPLE_W-1:0] scale_reg;
    logic [PCT_W-1:0]    white_pct_reg;
    logic [PCT_W-1:0]    black_pct_reg;

    t_light_result pending_results [$];

    int error_count   = 0;
    int idle_cycles   = 0;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    autorange_normalise_hysteresis dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_light_result normalise_sample(input logic [CH_W-1:0] ch,
                                                       input logic [SAMPLE_W-1:0] raw);
        t_light_result res;
        logic [63:0]   scaled;
        logic [PCT_W-1:0] up;
        logic [PCT_W-1:0] dn;
        res.ch    = ch;
        res.norm  = '0;
        res.white = 1'b0;
        if (int'(ch) < CHANNELS) begin
            if (raw >= track_max[ch]) track_max[ch] = raw;
            if (raw <= track_min[ch]) track_min[ch] = raw;
            scaled = '0;
            if (track_max[ch] > track_min[ch]) begin
                scaled = (64'(raw - track_min[ch]) * 64'(scale_reg))
                         / 64'(track_max[ch] - track_min[ch]);
            end
            up = (white_pct_reg > PCT_FULL) ? PCT_FULL : white_pct_reg;
            dn = (black_pct_reg > PCT_FULL) ? PCT_FULL : black_pct_reg;
            if (scaled * 64'(PCT_FULL) >= 64'(scale_reg) * 64'(PCT_FULL - up)) begin
                chan_white[ch] = 1'b1;
            end else if (scaled * 64'(PCT_FULL) <= 64'(scale_reg) * 64'(dn)) begin
                chan_white[ch] = 1'b0;
            end
            res.norm  = scaled[SAMPLE_W-1:0];
            res.white = chan_white[ch];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (error_count < MAX_REPORTS) begin
            $display("tb: mismatch on %s, got %0d, expected %0d, at %0t", field, got, want,
                     $realtime);
        end
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            CFG_FULL_SCALE: scale_reg     = data;
            CFG_UPPER_PCT:  white_pct_reg = data[PCT_W-1:0];
            CFG_LOWER_PCT:  black_pct_reg = data[PCT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] raw,
                               input logic typed, input logic [SAMPLE_W-1:0] want_norm,
                               input logic want_white);
        t_light_result predicted;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= ch;
        // Handshake signals are settled at the falling edge before the accepting edge.
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        predicted = normalise_sample(ch, raw);
        if (typed) begin
            predicted.norm  = want_norm;
            predicted.white = want_white;
        end
        pending_results.push_back(predicted);
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = PRESSURE_CYCLES;
        end
        if (!i_rst_n || hold_left > 0) begin
            m_axis_tready <= 1'b0;
            if (hold_left > 0) hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(negedge i_clk) begin
        t_light_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", int'(m_axis_tuser), -1);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.ch)
                    report_mismatch("out_channel", int'(m_axis_tuser), int'(want.ch));
                if (m_axis_tdata[SAMPLE_W-1:0] !== want.norm)
                    report_mismatch("normalised", int'(m_axis_tdata[SAMPLE_W-1:0]),
                                    int'(want.norm));
                if (m_axis_tdata[SAMPLE_W] !== want.white)
                    report_mismatch("is_white", int'(m_axis_tdata[SAMPLE_W]),
                                    int'(want.white));
                if (m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W+1] !== '0)
                    report_mismatch("fill bits", int'(m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W+1]),
                                    0);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] fs;
        logic [PCT_W-1:0]    up;
        logic [PCT_W-1:0]    dn;
        logic [SAMPLE_W-1:0] chan_base [4];
        logic [SAMPLE_W-1:0] chan_spread [4];
        int                  roll;

        for (int c = 0; c < CHANNELS; c++) begin
            track_max[c]  = RANGE_MAX_START;
            track_min[c]  = RANGE_MIN_START;
            chan_white[c] = 1'b0;
        end
        scale_reg     = FULL_SCALE_RST;
        white_pct_reg = UPPER_PCT_RST;
        black_pct_reg = LOWER_PCT_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == STEP_CONFIG) begin
                wait_drained();
                write_reg(DIRECTED[i].sel[CFG_ADDR_W-1:0], DIRECTED[i].value);
            end else begin
                send_sample(DIRECTED[i].sel, DIRECTED[i].value, DIRECTED[i].typed,
                            DIRECTED[i].want_norm, DIRECTED[i].want_white);
            end
        end

        for (int c = 0; c < 4; c++) begin
            chan_base[c]   = 16'($urandom);
            chan_spread[c] = 16'($urandom_range(15, 4095));
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin fs = 16'd1000;  up = 7'd20; dn = 7'd20; end
                1: begin fs = 16'd65535; up = 7'd0;  dn = 7'd0;  end
                2: begin fs = 16'd1;     up = 7'd50; dn = 7'd50; end
                default: begin
                    roll = $urandom_range(0, 9);
                    fs = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd65535
                                             : 16'($urandom_range(1, 65535));
                    up = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                     : 7'($urandom_range(0, 50));
                    dn = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                     : 7'($urandom_range(0, 50));
                end
            endcase
            write_reg(CFG_FULL_SCALE, fs);
            write_reg(CFG_UPPER_PCT, {9'($urandom), up});
            write_reg(CFG_LOWER_PCT, {9'($urandom), dn});

            case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 77; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 77; end
                default: begin send_gap_pct = 13; stall_pct = 13; end
            endcase
            if (phase == PRESSURE_PHASE) hold_requests++;

            repeat (ITEMS_PER_PHASE) begin
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
                roll = $urandom_range(0, 9);
                if (ch < 4) begin
                    raw = chan_base[ch[1:0]] + 16'($urandom_range(0, chan_spread[ch[1:0]]));
                end else if (roll == 0) begin
                    raw = 16'd0;
                end else if (roll == 1) begin
                    raw = 16'd65535;
                end else begin
                    raw = 16'($urandom);
                end
                send_sample(ch, raw, 1'b0, 16'd0, 1'b0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
